/* sv/sensor_running_average_table_defines.svh */
// ----------------------------------------------------------------------------
// Sensor running average table assertion macros
// Concurrent check macros clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SENSOR_RUNNING_AVERAGE_TABLE_DEFINES_SVH
`define SENSOR_RUNNING_AVERAGE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define SRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define SRA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define SRA_ASSERT(lbl, prop, msg)
`define SRA_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* sv/sra_pkg.sv */
// ----------------------------------------------------------------------------
// Sensor running average table package
// Item types, status codes, register indexes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package sra_pkg;

  localparam int unsigned ID_W      = 16;
  localparam int unsigned TEMP_W    = 16;
  localparam int unsigned TS_W      = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned STATUS_W  = 2;

  // Operation codes of an input item.
  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_READING  = 1'b1;

  // Status codes of a result item.
  localparam logic [STATUS_W-1:0] STATUS_APPLIED    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REGISTERED = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd3;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 1'b1;
  localparam logic signed [CFG_W-1:0] MAX_TEMP_RST = 16'sd6400;
  localparam logic signed [CFG_W-1:0] MIN_TEMP_RST = 16'sd2560;

  typedef struct packed {
    logic                     op;
    logic [ID_W-1:0]          sensor_key;
    logic [ID_W-1:0]          room_id;
    logic signed [TEMP_W-1:0] temperature;
    logic [TS_W-1:0]          timestamp;
  } sra_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [ID_W-1:0]          room_number;
    logic signed [TEMP_W-1:0] average;
    logic [TS_W-1:0]          last_seen;
    logic                     too_hot;
    logic                     too_cold;
  } sra_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REG,
    S_READ,
    S_CHECK,
    S_SUM,
    S_DIVGO,
    S_DIVWAIT,
    S_WRITE,
    S_FIN
  } sra_state_e;

endpackage

`default_nettype wire

/* sv/sra_divider.sv */
// ----------------------------------------------------------------------------
// Sensor running average table divider
// Bit-serial restoring division of a signed sum by a small unsigned count,
// truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_divider
  import sra_pkg::*;
#(
  parameter int unsigned NUM_W = 19,
  parameter int unsigned DEN_W = 3,
  parameter int unsigned Q_W   = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0]        den_i,
  output logic                         done_o,
  output logic [Q_W-1:0]               quot_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic              neg_q;
  logic [NUM_W-1:0]  shreg_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W:0]    trial;
  logic              fits;
  logic [NUM_W-1:0]  mag_in;

  // Partial remainder with the next dividend bit brought down.
  assign trial  = {rem_q, shreg_q[NUM_W-1]};
  assign fits   = (trial >= {1'b0, den_q});
  assign mag_in = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);

  // Step counter; done pulses for one cycle after the last step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q   <= num_i[NUM_W-1];
      shreg_q <= mag_in;
      rem_q   <= '0;
      den_q   <= den_i;
    end else if (busy_q) begin
      shreg_q <= {shreg_q[NUM_W-2:0], fits};
      rem_q   <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    end
  end

  // Restore the sign of the truncated quotient.
  assign done_o = done_q;
  assign quot_o = neg_q ? Q_W'(-shreg_q) : Q_W'(shreg_q);

endmodule

`default_nettype wire

/* sv/sensor_running_average_table.sv */
// ----------------------------------------------------------------------------
// Sensor running average table
// Per-sensor table of temperature windows with running averages and alarms.
// ----------------------------------------------------------------------------
// Items are taken one at a time; the block raises in_stall_o until the result
// has been handed to the output register, which lets the next item in while
// that result still waits. A reading walks all registered entries through the
// entry memory, one entry at a time, and each entry whose id matches is summed
// over its SLOTS slots, divided by the bit-serial divider over a SUM_W-bit sum
// (SUM_W = 16 + clog2(SLOTS), 19 by default) and written back. Entries are
// filled in order and tracked by a fill count, so no clearing pass is needed
// after reset. Readings for an unknown sensor report status 1, a register item
// on a full table reports status 3.
`default_nettype none
`include "sensor_running_average_table_defines.svh"

module sensor_running_average_table
  import sra_pkg::*;
#(
  parameter int unsigned SLOTS   = 5,
  parameter int unsigned ENTRIES = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire sra_in_t              in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output sra_out_t                  out_item_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned ENT_CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W     = $clog2(SLOTS + 1);
  localparam int unsigned SUM_W     = TEMP_W + $clog2(SLOTS);

  typedef struct packed {
    logic [ID_W-1:0]               sensor;
    logic [ID_W-1:0]               room;
    logic [SLOTS-1:0][TEMP_W-1:0]  win;
    logic [SLOTS-1:0]              vld;
    logic [TEMP_W-1:0]             mean;
    logic [TS_W-1:0]               stamp;
  } entry_t;

  sra_state_e state_q, state_d;

  logic signed [CFG_W-1:0]      max_temp_q;
  logic signed [CFG_W-1:0]      min_temp_q;
  logic [ENT_CNT_W-1:0]         count_q;
  logic [ENT_CNT_W-1:0]         idx_q;
  logic [ENT_CNT_W-1:0]         idx_next;
  logic                         out_valid_q;
  sra_out_t                     out_item_q;
  sra_in_t                      item_q;
  sra_out_t                     res_q;
  entry_t                       rd_data_q;
  logic [SLOTS-1:0][TEMP_W-1:0] win_q;
  logic [SLOTS-1:0][TEMP_W-1:0] win_shift;
  logic [SLOTS-1:0]             vld_q;
  logic signed [SUM_W-1:0]      sum_q;
  logic signed [SUM_W-1:0]      sum_add;
  logic [CNT_W-1:0]             cnt_q;
  logic [SLOT_W-1:0]            slot_q;
  logic [TEMP_W-1:0]            mean_q;

  entry_t entry_mem [ENTRIES];

  logic              accept;
  logic              table_full;
  logic              tag_hit;
  logic              walk_last;
  logic              slot_last;
  logic              out_free;
  logic              out_load;
  logic              mem_re;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;
  logic              div_start;
  logic              div_done;
  logic [TEMP_W-1:0] div_quot;

  assign accept     = in_valid_i && !in_stall_o;
  assign table_full = (count_q == ENT_CNT_W'(ENTRIES));
  assign tag_hit    = (rd_data_q.sensor == item_q.sensor_key);
  assign idx_next   = idx_q + 1'b1;
  assign walk_last  = (idx_next == count_q);
  assign slot_last  = (slot_q == SLOT_W'(SLOTS - 1));
  assign out_free   = !out_valid_q || !out_stall_i;

  // Window after a reading: older values move up one slot, the new one lands
  // in slot zero.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      if (i == 0) begin
        win_shift[i] = item_q.temperature;
      end else begin
        win_shift[i] = rd_data_q.win[i-1];
      end
    end
  end

  // Signed contribution of the slot under the accumulator.
  assign sum_add = vld_q[slot_q] ? SUM_W'($signed(win_q[slot_q])) : '0;

  // Controller next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_item_i.op == OP_REGISTER) begin
            state_d = S_REG;
          end else if (count_q == '0) begin
            state_d = S_FIN;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_REG:   state_d = S_FIN;
      S_READ:  state_d = S_CHECK;
      S_CHECK: begin
        if (tag_hit) begin
          state_d = S_SUM;
        end else if (walk_last) begin
          state_d = S_FIN;
        end else begin
          state_d = S_READ;
        end
      end
      S_SUM: begin
        if (slot_last) begin
          state_d = S_DIVGO;
        end
      end
      S_DIVGO: state_d = S_DIVWAIT;
      S_DIVWAIT: begin
        if (div_done) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: state_d = walk_last ? S_FIN : S_READ;
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Controller outputs: memory port, divider start and handshakes.
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = idx_q[ADDR_W-1:0];
    mem_wdata  = '{sensor: rd_data_q.sensor, room: rd_data_q.room, win: win_q,
                   vld: vld_q, mean: mean_q, stamp: item_q.timestamp};
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      S_REG: begin
        mem_we    = !table_full;
        mem_waddr = count_q[ADDR_W-1:0];
        mem_wdata = '{sensor: item_q.sensor_key, room: item_q.room_id, win: '0,
                      vld: '0, mean: '0, stamp: '0};
      end
      S_READ:  mem_re    = 1'b1;
      S_DIVGO: div_start = 1'b1;
      S_WRITE: mem_we    = 1'b1;
      S_FIN:   out_load  = out_free;
      default: begin
      end
    endcase
  end

  // Entry memory: one write port, one registered read port. Each matching entry
  // is read, updated and written back before the next one is read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= entry_mem[idx_q[ADDR_W-1:0]];
    end
  end

  // Bit-serial mean of the valid slots.
  sra_divider #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W),
    .Q_W   (TEMP_W)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q),
    .den_i   (cnt_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Control state: controller, fill count, walk index, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_REG && !table_full) begin
        count_q <= count_q + 1'b1;
      end
      if (accept) begin
        idx_q <= '0;
      end else if ((state_q == S_CHECK && !tag_hit) || state_q == S_WRITE) begin
        idx_q <= idx_next;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Threshold registers; the user must write them only while the block is idle, the block itself does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_temp_q <= MAX_TEMP_RST;
      min_temp_q <= MIN_TEMP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_TEMP: max_temp_q <= cfg_data_i;
        CFG_MIN_TEMP: min_temp_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Working registers of the current item and entry.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
      res_q  <= '{status: STATUS_UNKNOWN, room_number: '0, average: '0,
                  last_seen: '0, too_hot: 1'b0, too_cold: 1'b0};
    end
    case (state_q)
      S_REG: begin
        if (table_full) begin
          res_q.status <= STATUS_FULL;
        end else begin
          res_q.status      <= STATUS_REGISTERED;
          res_q.room_number <= item_q.room_id;
        end
      end
      S_CHECK: begin
        win_q  <= win_shift;
        vld_q  <= SLOTS'({rd_data_q.vld, 1'b1});
        sum_q  <= '0;
        cnt_q  <= '0;
        slot_q <= '0;
      end
      S_SUM: begin
        sum_q  <= sum_q + sum_add;
        cnt_q  <= cnt_q + CNT_W'(vld_q[slot_q]);
        slot_q <= slot_q + 1'b1;
      end
      S_DIVWAIT: begin
        if (div_done) begin
          mean_q <= div_quot;
        end
      end
      S_WRITE: begin
        // Later matches overwrite earlier ones, so the newest entry wins.
        res_q.status      <= STATUS_APPLIED;
        res_q.room_number <= rd_data_q.room;
        res_q.average     <= mean_q;
        res_q.last_seen   <= item_q.timestamp;
        res_q.too_hot     <= ($signed(mean_q) > max_temp_q);
        res_q.too_cold    <= ($signed(mean_q) < min_temp_q);
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_item_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The fill count never runs past the table size.
  `SRA_ASSERT(a_count_bound, count_q <= ENT_CNT_W'(ENTRIES), "fill count beyond table size")
  // Only a register item may grow the table.
  `SRA_ASSERT(a_count_only_reg, state_q != S_REG |=> count_q == $past(count_q), "count moved outside register step")
  // A mean is only taken over at least one and at most SLOTS valid slots.
  `SRA_ASSERT(a_div_count, state_q == S_DIVGO |-> (cnt_q != '0 && cnt_q <= CNT_W'(SLOTS)), "bad divisor")
  // The divider finishes only while the controller waits for it.
  `SRA_ASSERT_NEVER(a_div_done_state, div_done && state_q != S_DIVWAIT, "divider done outside wait")

endmodule

`default_nettype wire

/* tb/tb_sensor_running_average_table.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor running average table testbench
// Drives register and reading items through the valid/stall channels under
// random idling on both sides. Every report is checked field by field against
// a model of the table kept in this file, or a typed row's want. Directed rows
// run first, then random traffic under four threshold settings, extremes too.
// ----------------------------------------------------------------------------

module tb_sensor_running_average_table;
  import sra_pkg::*;

  localparam int unsigned SLOTS         = 5;
  localparam int unsigned ENTRIES       = 32;
  localparam int unsigned HANG_LIMIT    = 20000;
  localparam int unsigned TAIL_CYCLES   = 1000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_SHOWN     = 10;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    sra_in_t  item;
    logic     typed;
    sra_out_t want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  sra_in_t              in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  sra_out_t             out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_MAX_TEMP;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Model of the sensor table and its thresholds.
  int unsigned              ent_count = 0;
  logic [ID_W-1:0]          ent_sensor [ENTRIES];
  logic [ID_W-1:0]          ent_room   [ENTRIES];
  logic signed [TEMP_W-1:0] ent_win    [ENTRIES][SLOTS];
  logic [SLOTS-1:0]         ent_valid  [ENTRIES];
  logic signed [TEMP_W-1:0] ent_mean   [ENTRIES];
  logic [TS_W-1:0]          ent_seen   [ENTRIES];
  logic signed [CFG_W-1:0]  lim_hot  = MAX_TEMP_RST;
  logic signed [CFG_W-1:0]  lim_cold = MIN_TEMP_RST;

  sra_out_t    pending_reports [$];
  int unsigned bad_reports = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  dir_row_t    directed_rows [$];

  sensor_running_average_table #(
    .SLOTS   (SLOTS),
    .ENTRIES (ENTRIES)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // Free-running clock.
  initial begin
    forever #2 clk = ~clk;
  end

  // Applies one item to the table model and returns the report it causes.
  function automatic sra_out_t apply_to_table(sra_in_t it);
    sra_out_t rep;
    int       sum;
    int       cnt;
    int       newest;
    int       e;
    int       s;
    rep = '0;
    newest = -1;
    if (it.op == OP_REGISTER) begin
      if (ent_count >= ENTRIES) begin
        rep.status = STATUS_FULL;
      end else begin
        ent_sensor[ent_count] = it.sensor_key;
        ent_room[ent_count]   = it.room_id;
        for (s = 0; s < SLOTS; s++) ent_win[ent_count][s] = '0;
        ent_valid[ent_count] = '0;
        ent_mean[ent_count]  = '0;
        ent_seen[ent_count]  = '0;
        ent_count++;
        rep.status      = STATUS_REGISTERED;
        rep.room_number = it.room_id;
      end
      return rep;
    end
    // A reading updates every entry of that sensor; the newest one reports.
    for (e = 0; e < ent_count; e++) begin
      if (ent_sensor[e] == it.sensor_key) begin
        for (s = SLOTS - 1; s > 0; s--) ent_win[e][s] = ent_win[e][s-1];
        ent_win[e][0] = it.temperature;
        ent_valid[e]  = {ent_valid[e][SLOTS-2:0], 1'b1};
        sum = 0;
        cnt = 0;
        for (s = 0; s < SLOTS; s++) begin
          if (ent_valid[e][s]) begin
            sum += ent_win[e][s];
            cnt++;
          end
        end
        ent_mean[e] = 16'(sum / cnt);
        ent_seen[e] = it.timestamp;
        newest = e;
      end
    end
    if (newest < 0) begin
      rep.status = STATUS_UNKNOWN;
    end else begin
      rep.status      = STATUS_APPLIED;
      rep.room_number = ent_room[newest];
      rep.average     = ent_mean[newest];
      rep.last_seen   = ent_seen[newest];
      rep.too_hot     = (ent_mean[newest] > lim_hot);
      rep.too_cold    = (ent_mean[newest] < lim_cold);
    end
    return rep;
  endfunction

  function automatic sra_in_t reg_item(logic [ID_W-1:0] sid, logic [ID_W-1:0] room);
    sra_in_t it;
    it = '0;
    it.op         = OP_REGISTER;
    it.sensor_key = sid;
    it.room_id    = room;
    return it;
  endfunction

  function automatic sra_in_t read_item(logic [ID_W-1:0] sid,
                                        logic signed [TEMP_W-1:0] temp,
                                        logic [TS_W-1:0] ts);
    sra_in_t it;
    it = '0;
    it.op          = OP_READING;
    it.sensor_key  = sid;
    it.temperature = temp;
    it.timestamp   = ts;
    return it;
  endfunction

  function automatic sra_out_t report(logic [STATUS_W-1:0] st, logic [ID_W-1:0] room,
                                      logic signed [TEMP_W-1:0] avg, logic [TS_W-1:0] seen,
                                      logic hot, logic cold);
    sra_out_t rep;
    rep.status      = st;
    rep.room_number = room;
    rep.average     = avg;
    rep.last_seen   = seen;
    rep.too_hot     = hot;
    rep.too_cold    = cold;
    return rep;
  endfunction

  // Random item: mostly readings of registered sensors, some registrations,
  // duplicates among them, and readings of ids that are likely unknown.
  function automatic sra_in_t random_item();
    sra_in_t it;
    int unsigned reg_pct;
    it.room_id   = 16'($urandom_range(16'hFFFF));
    it.timestamp = $urandom();
    case ($urandom_range(3))
      0, 1:    it.temperature = 16'($urandom_range(12800));
      2:       it.temperature = 16'(int'($urandom_range(25600)) - 12800);
      default: it.temperature = 16'($urandom());
    endcase
    reg_pct = (ent_count < ENTRIES) ? 8 : 4;
    if ($urandom_range(99) < reg_pct) begin
      it.op = OP_REGISTER;
      if (ent_count != 0 && $urandom_range(99) < 30)
        it.sensor_key = ent_sensor[$urandom_range(ent_count - 1)];
      else
        it.sensor_key = 16'($urandom_range(16'hFFFF));
    end else begin
      it.op = OP_READING;
      if (ent_count != 0 && $urandom_range(99) < 85)
        it.sensor_key = ent_sensor[$urandom_range(ent_count - 1)];
      else
        it.sensor_key = 16'($urandom_range(16'hFFFF));
    end
    return it;
  endfunction

  // Offers one item after an optional gap and logs its expected report.
  task automatic send_item(input sra_in_t it, input logic typed, input sra_out_t want);
    sra_out_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    predicted = apply_to_table(it);
    pending_reports.push_back(typed ? want : predicted);
  endtask

  task automatic random_items(input int unsigned n);
    repeat (n) send_item(random_item(), 1'b0, '0);
  endtask

  // Holds the sender back until every expected report has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both thresholds; only called while the block is idle.
  task automatic set_limits(input logic signed [CFG_W-1:0] hot,
                            input logic signed [CFG_W-1:0] cold);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_MAX_TEMP;
    cfg_data <= hot;
    @(posedge clk);
    cfg_idx  <= CFG_MIN_TEMP;
    cfg_data <= cold;
    @(posedge clk);
    cfg_we   <= 1'b0;
    lim_hot  = hot;
    lim_cold = cold;
  endtask

  task automatic note_mismatch(input string what, input sra_out_t want, input sra_out_t got);
    bad_reports++;
    if (bad_reports <= MAX_SHOWN)
      $display("%0t report mismatch (%s): expected st=%0d room=%h avg=%0d seen=%h hot=%b cold=%b, got st=%0d room=%h avg=%0d seen=%h hot=%b cold=%b",
               $realtime, what, want.status, want.room_number, want.average, want.last_seen,
               want.too_hot, want.too_cold, got.status, got.room_number, got.average,
               got.last_seen, got.too_hot, got.too_cold);
  endtask

  // Compares one accepted report with the oldest expectation.
  task automatic check_report(input sra_out_t got);
    sra_out_t want;
    string    bad;
    bad = "";
    if (pending_reports.size() == 0) begin
      note_mismatch("no report expected", '0, got);
    end else begin
      want = pending_reports.pop_front();
      if (got.status      !== want.status)      bad = {bad, " status"};
      if (got.room_number !== want.room_number) bad = {bad, " room_number"};
      if (got.average     !== want.average)     bad = {bad, " average"};
      if (got.last_seen   !== want.last_seen)   bad = {bad, " last_seen"};
      if (got.too_hot     !== want.too_hot)     bad = {bad, " too_hot"};
      if (got.too_cold    !== want.too_cold)    bad = {bad, " too_cold"};
      if (bad.len() != 0) note_mismatch({"wrong", bad}, want, got);
    end
  endtask

  // Result side: checks accepted reports and draws the next stall.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_report(out_item);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    directed_rows = '{
      '{read_item(16'h1234, 16'sh0100, 32'd1), 1'b1,
        report(STATUS_UNKNOWN, 16'h0, 16'sh0, 32'h0, 1'b0, 1'b0)},
      '{reg_item(16'h1234, 16'hFFFF), 1'b1,
        report(STATUS_REGISTERED, 16'hFFFF, 16'sh0, 32'h0, 1'b0, 1'b0)},
      '{reg_item(16'h0000, 16'h0000), 1'b1,
        report(STATUS_REGISTERED, 16'h0000, 16'sh0, 32'h0, 1'b0, 1'b0)},
      '{reg_item(16'hFFFF, 16'h8001), 1'b1,
        report(STATUS_REGISTERED, 16'h8001, 16'sh0, 32'h0, 1'b0, 1'b0)},
      '{read_item(16'h1234, 16'sh7FFF, 32'hFFFF_FFFF), 1'b1,
        report(STATUS_APPLIED, 16'hFFFF, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1, 1'b0)},
      '{read_item(16'h1234, 16'sh8000, 32'h0), 1'b0, '0},
      '{read_item(16'h0000, 16'sh8000, 32'd1), 1'b1,
        report(STATUS_APPLIED, 16'h0000, 16'sh8000, 32'd1, 1'b0, 1'b1)},
      '{read_item(16'h0000, 16'sd999, 32'd2), 1'b0, '0},
      '{reg_item(16'h1234, 16'h0042), 1'b1,
        report(STATUS_REGISTERED, 16'h0042, 16'sh0, 32'h0, 1'b0, 1'b0)},
      '{read_item(16'h1234, 16'sd2560, 32'd5), 1'b1,
        report(STATUS_APPLIED, 16'h0042, 16'sd2560, 32'd5, 1'b0, 1'b0)},
      '{read_item(16'h1234, 16'sd6401, 32'd6), 1'b0, '0},
      '{read_item(16'h1234, 16'sd6400, 32'd7), 1'b0, '0},
      '{read_item(16'hFFFF, 16'sd100, 32'd10), 1'b0, '0},
      '{read_item(16'hFFFF, 16'sd200, 32'd11), 1'b0, '0},
      '{read_item(16'hFFFF, 16'sd300, 32'd12), 1'b0, '0},
      '{read_item(16'hFFFF, 16'sd400, 32'd13), 1'b0, '0},
      '{read_item(16'hFFFF, 16'sd500, 32'd14), 1'b0, '0},
      '{read_item(16'hFFFF, 16'sd600, 32'd15), 1'b0, '0},
      '{read_item(16'hFFFF, 16'sd700, 32'd16), 1'b0, '0},
      '{read_item(16'hABCD, 16'sh7FFF, 32'd17), 1'b1,
        report(STATUS_UNKNOWN, 16'h0, 16'sh0, 32'h0, 1'b0, 1'b0)},
      '{read_item(16'h0000, 16'sh7FFF, 32'h8000_0000), 1'b0, '0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver stalls often; thresholds at reset values.
    send_idle_pct  = 26;
    recv_stall_pct = 55;
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    random_items(110);
    drain();
    random_items(110);

    // Roles swapped; thresholds at the extremes so no alarm can fire.
    drain();
    set_limits(16'sh7FFF, 16'sh8000);
    send_idle_pct  = 55;
    recv_stall_pct = 26;
    random_items(220);

    // No idling; inverted extremes so nearly every average raises both flags.
    drain();
    set_limits(16'sh8000, 16'sh7FFF);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_items(180);

    // No idling; thresholds in the range that the readings mostly cover.
    drain();
    set_limits(16'($urandom_range(9000, 4000)), 16'($urandom_range(4000)));
    random_items(210);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_reports == 0 && pending_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sensor_running_average_table.f */
+incdir+sv
sv/sra_pkg.sv
sv/sra_divider.sv
sv/sensor_running_average_table.sv
tb/tb_sensor_running_average_table.sv
